// ===== rtl/sacm_pkg.sv =====
// Shared types and constants for the set-associative cache tag-store model.
`default_nettype none
package sacm_pkg;

   localparam int unsigned MEM_WORD_CYCLES = 100;
   localparam int unsigned HIT_CYCLES      = 1;

   localparam logic [2:0] CSR_SET_BITS     = 3'd0;
   localparam logic [2:0] CSR_WAY_COUNT    = 3'd1;
   localparam logic [2:0] CSR_OFFSET_BITS  = 3'd2;
   localparam logic [2:0] CSR_WRITE_POLICY = 3'd3;
   localparam logic [2:0] CSR_USE_LRU      = 3'd4;

   localparam logic [1:0] POL_ALLOC_WB  = 2'd0;
   localparam logic [1:0] POL_ALLOC_WT  = 2'd1;
   localparam logic [1:0] POL_NOALLOC   = 2'd2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_STORE = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        dirty_evicted;
      logic [15:0] access_cycles;
      logic [31:0] cycles_total;
      logic [31:0] load_hit_count;
      logic [31:0] load_miss_count;
      logic [31:0] store_hit_count;
      logic [31:0] store_miss_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_SCAN,
      ST_UPDATE,
      ST_COST,
      ST_DONE
   } state_type;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [32:0] b);
      logic [33:0] s;
      s = {2'b00, a} + {1'b0, b};
      return (s > 34'h0FFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/sacm_way_mem.sv =====
// Per-way metadata memory: one row per set, holding all ways of that set.
`default_nettype none
module sacm_way_mem #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned WIDTH = 8
) (
   input  wire logic                                          clock,
   input  wire logic                                          wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                              wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/set_assoc_cache_model.sv =====
// Top level of the set-associative cache tag-store model.
//  channel  ports                               direction  note
//  request  start, busy, req_data               in         taken when start && !busy
//  result   rsp_valid, rsp_data                 out        one-cycle strobe, cannot stall
//  config   csr_we, csr_index, csr_wdata        in         write only, any cycle while idle
// An access runs from accept to result through one metadata row read, a way scan that
// compares one way per cycle (ending at a hit or the last way in use), row update,
// cost add, result. busy is low again in the result cycle.
// After reset a clearing pass writes zero to every row of the metadata memory; busy
// stays high meanwhile. The receiver cannot stall; results are one-cycle strobes.
`default_nettype none
module set_assoc_cache_model #(
   parameter int unsigned MAX_SETS        = 256,
   parameter int unsigned MAX_WAYS        = 8,
   parameter int unsigned MAX_OFFSET_BITS = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire sacm_pkg::req_type req_data,
   output logic                  rsp_valid,
   output sacm_pkg::rsp_type     rsp_data,
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [3:0]       csr_wdata
);
   localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int unsigned CNT_W  = $clog2(MAX_WAYS + 1);
   localparam int unsigned MAX_SB = $clog2(MAX_SETS + 1) - 1;
   // ages never exceed MAX_WAYS - 1
   localparam int unsigned AGE_W  = WAY_W;
   localparam int unsigned TAG_W  = 30;
   // per way: valid, dirty, recency, fill age, tag
   localparam int unsigned ENT_W  = 2 + 2 * AGE_W + TAG_W;
   localparam int unsigned ROW_W  = ENT_W * MAX_WAYS + CNT_W;

   typedef struct packed {
      logic             valid;
      logic             dirty;
      logic [AGE_W-1:0] rec;
      logic [AGE_W-1:0] fil;
      logic [TAG_W-1:0] tag;
   } ent_type;

   // configuration
   logic [3:0] set_bits_ff, way_count_ff, offset_bits_ff;
   logic [1:0] write_policy_ff;
   logic       use_lru_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff     <= 4'd0;
         way_count_ff    <= 4'd1;
         offset_bits_ff  <= 4'd4;
         write_policy_ff <= sacm_pkg::POL_ALLOC_WB;
         use_lru_ff      <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            sacm_pkg::CSR_SET_BITS:     set_bits_ff     <= csr_wdata;
            sacm_pkg::CSR_WAY_COUNT:    way_count_ff    <= csr_wdata;
            sacm_pkg::CSR_OFFSET_BITS:  offset_bits_ff  <= csr_wdata;
            sacm_pkg::CSR_WRITE_POLICY: write_policy_ff <= csr_wdata[1:0];
            sacm_pkg::CSR_USE_LRU:      use_lru_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective configuration
   logic [4:0] sb_eff, ob_eff;
   logic [6:0] ways_eff;
   logic [1:0] pol_eff;
   logic       wb, alloc;

   always_comb begin
      sb_eff = ({1'b0, set_bits_ff} > 5'(MAX_SB)) ? 5'(MAX_SB) : {1'b0, set_bits_ff};
      if (way_count_ff == 4'd0) begin
         ways_eff = 7'd1;
      end else if ({3'b000, way_count_ff} > 7'(MAX_WAYS)) begin
         ways_eff = 7'(MAX_WAYS);
      end else begin
         ways_eff = {3'b000, way_count_ff};
      end
      if (offset_bits_ff < 4'd2) begin
         ob_eff = 5'd2;
      end else if ({1'b0, offset_bits_ff} > 5'(MAX_OFFSET_BITS)) begin
         ob_eff = 5'(MAX_OFFSET_BITS);
      end else begin
         ob_eff = {1'b0, offset_bits_ff};
      end
      pol_eff = (write_policy_ff > sacm_pkg::POL_NOALLOC) ? sacm_pkg::POL_NOALLOC
                                                          : write_policy_ff;
      wb    = (pol_eff == sacm_pkg::POL_ALLOC_WB);
      alloc = (pol_eff != sacm_pkg::POL_NOALLOC);
   end

   // control
   sacm_pkg::state_type state_ff, state_in;
   logic [SET_W:0]    clr_ff, clr_in;
   logic [WAY_W:0]    j_ff, j_in;
   logic              store_ff;
   logic [SET_W-1:0]  set_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [ROW_W-1:0]  row_ff;
   logic              hit_ff, dev_ff;
   logic [WAY_W-1:0]  h_ff, v_ff;
   logic [AGE_W-1:0]  best_ff;
   logic [32:0]       cost_ff;
   logic [31:0]       total_ff;
   logic [31:0]       cnt_ff [4];
   logic              rsp_valid_ff;
   sacm_pkg::rsp_type rsp_ff;

   logic [ROW_W-1:0] rd_row;
   logic             mem_we;
   logic [SET_W-1:0] mem_waddr;
   logic [ROW_W-1:0] mem_wdata;

   sacm_way_mem #(.DEPTH(MAX_SETS), .WIDTH(ROW_W)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (set_ff),
      .rd_data (rd_row)
   );

   // first scan cycle works from the memory output, later ones from the captured row
   ent_type ent [MAX_WAYS];
   logic [ROW_W-1:0] scan_row;
   logic [CNT_W-1:0] fill_raw;
   logic [6:0]       n_eff;
   always_comb begin
      scan_row = (state_ff == sacm_pkg::ST_SCAN && j_ff == '0) ? rd_row : row_ff;
      for (int k = 0; k < MAX_WAYS; k++) begin
         ent[k] = scan_row[CNT_W + k * ENT_W +: ENT_W];
      end
      fill_raw = scan_row[CNT_W-1:0];
      n_eff = (7'(fill_raw) > ways_eff) ? ways_eff : 7'(fill_raw);
   end

   // shared compare unit: one way per scan cycle
   ent_type          cur;
   logic             in_use, tag_eq;
   always_comb begin
      cur     = ent[j_ff[WAY_W-1:0]];
      in_use  = (7'(j_ff) < n_eff);
      tag_eq  = cur.valid && (cur.tag == tag_ff);
   end

   logic scan_last;
   assign scan_last = (7'(j_ff) >= n_eff - 7'd1) || (n_eff == 7'd0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sacm_pkg::ST_CLEAR:  if (clr_ff == (SET_W + 1)'(MAX_SETS - 1)) state_in = sacm_pkg::ST_IDLE;
         sacm_pkg::ST_IDLE:   if (start) state_in = sacm_pkg::ST_READ;
         sacm_pkg::ST_READ:   state_in = sacm_pkg::ST_SCAN;
         sacm_pkg::ST_SCAN:   if (scan_last || (in_use && tag_eq)) state_in = sacm_pkg::ST_UPDATE;
         sacm_pkg::ST_UPDATE: state_in = sacm_pkg::ST_COST;
         sacm_pkg::ST_COST:   state_in = sacm_pkg::ST_DONE;
         sacm_pkg::ST_DONE:   state_in = sacm_pkg::ST_IDLE;
         default:             state_in = sacm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      clr_in = clr_ff;
      j_in   = j_ff;
      case (state_ff)
         sacm_pkg::ST_CLEAR: clr_in = clr_ff + 1'b1;
         sacm_pkg::ST_READ:  j_in   = '0;
         sacm_pkg::ST_SCAN:  j_in   = j_ff + 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sacm_pkg::ST_CLEAR;
         clr_ff   <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         j_ff     <= j_in;
      end
   end

   // row update
   logic [ROW_W-1:0] new_row;
   logic             do_fill;
   logic             full;
   logic [WAY_W-1:0] slot;
   logic             ev_dirty;
   always_comb begin
      ent_type e;
      ent_type vic;
      new_row = row_ff;
      full    = (n_eff >= ways_eff);
      do_fill = !hit_ff && (alloc || !store_ff);
      vic     = ent[v_ff];
      slot    = full ? v_ff : n_eff[WAY_W-1:0];
      ev_dirty = do_fill && full && vic.valid && vic.dirty;
      for (int k = 0; k < MAX_WAYS; k++) begin
         e = ent[k];
         if (k < n_eff) begin
            if (hit_ff) begin
               if (WAY_W'(k) == h_ff) begin
                  e.rec = '0;
                  if (store_ff && wb) e.dirty = 1'b1;
               end else if (e.valid && e.rec < ent[h_ff].rec) begin
                  e.rec = e.rec + 1'b1;
               end
            end else if (do_fill) begin
               if (full) begin
                  if (WAY_W'(k) != v_ff) begin
                     if (e.rec < vic.rec) e.rec = e.rec + 1'b1;
                     if (e.fil < vic.fil) e.fil = e.fil + 1'b1;
                  end
               end else begin
                  e.rec = e.rec + 1'b1;
                  e.fil = e.fil + 1'b1;
               end
            end
         end
         if (do_fill && WAY_W'(k) == slot) begin
            e.valid = 1'b1;
            e.dirty = store_ff && wb;
            e.rec   = '0;
            e.fil   = '0;
            e.tag   = tag_ff;
         end
         new_row[CNT_W + k * ENT_W +: ENT_W] = e;
      end
      if (do_fill && !full) new_row[CNT_W-1:0] = n_eff[CNT_W-1:0] + 1'b1;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = set_ff;
      mem_wdata = new_row;
      if (state_ff == sacm_pkg::ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff[SET_W-1:0];
         mem_wdata = '0;
      end else if (state_ff == sacm_pkg::ST_UPDATE) begin
         mem_we = 1'b1;
      end
   end

   // line transfer cost: 100 * 2^(ob-2)
   logic [32:0] words100;
   logic [32:0] cost_base;
   assign words100 = 33'(sacm_pkg::MEM_WORD_CYCLES) << (ob_eff - 5'd2);
   always_comb begin
      if (hit_ff) begin
         cost_base = (store_ff && !wb) ? 33'(sacm_pkg::HIT_CYCLES + sacm_pkg::MEM_WORD_CYCLES)
                                       : 33'(sacm_pkg::HIT_CYCLES);
      end else if (!store_ff || wb) begin
         cost_base = 33'(sacm_pkg::HIT_CYCLES) + words100;
      end else if (alloc) begin
         cost_base = 33'(sacm_pkg::HIT_CYCLES + sacm_pkg::MEM_WORD_CYCLES) + words100;
      end else begin
         cost_base = 33'(sacm_pkg::MEM_WORD_CYCLES);
      end
   end

   logic [1:0] k_idx;
   assign k_idx = {store_ff, !hit_ff};

   // scan compare: row is captured on first scan cycle, so compare from memory output then
   ent_type          scan_e;
   logic [AGE_W-1:0] scan_age;
   logic             scan_eq;
   always_comb begin
      scan_e   = (j_ff == '0) ? ent_type'(rd_row[CNT_W +: ENT_W]) : cur;
      scan_age = use_lru_ff ? scan_e.rec : scan_e.fil;
      scan_eq  = scan_e.valid && (scan_e.tag == tag_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == sacm_pkg::ST_IDLE && start) begin
         store_ff <= req_data.operation;
         set_ff   <= SET_W'((req_data.address >> ob_eff) & ((32'd1 << sb_eff) - 32'd1));
         tag_ff   <= TAG_W'(req_data.address >> (ob_eff + sb_eff));
      end
      if (state_ff == sacm_pkg::ST_READ) begin
         hit_ff  <= 1'b0;
         h_ff    <= '0;
         v_ff    <= '0;
         best_ff <= '0;
      end
      if (state_ff == sacm_pkg::ST_SCAN) begin
         if (j_ff == '0) row_ff <= rd_row;
         if (in_use && !hit_ff) begin
            if (scan_eq) begin
               hit_ff <= 1'b1;
               h_ff   <= j_ff[WAY_W-1:0];
            end
            if (j_ff == '0 || scan_age > best_ff) begin
               best_ff <= scan_age;
               v_ff    <= j_ff[WAY_W-1:0];
            end
         end
      end
      if (state_ff == sacm_pkg::ST_UPDATE) begin
         dev_ff  <= ev_dirty;
         cost_ff <= cost_base + (ev_dirty ? words100 : 33'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         for (int k = 0; k < 4; k++) cnt_ff[k] <= '0;
      end else if (state_ff == sacm_pkg::ST_COST) begin
         total_ff      <= sacm_pkg::sat_add32(total_ff, cost_ff);
         cnt_ff[k_idx] <= sacm_pkg::sat_add32(cnt_ff[k_idx], 33'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == sacm_pkg::ST_DONE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == sacm_pkg::ST_DONE) begin
         rsp_ff.hit              <= hit_ff;
         rsp_ff.dirty_evicted    <= dev_ff;
         rsp_ff.access_cycles    <= (cost_ff > 33'hFFFF) ? 16'hFFFF : cost_ff[15:0];
         rsp_ff.cycles_total     <= total_ff;
         rsp_ff.load_hit_count   <= cnt_ff[0];
         rsp_ff.load_miss_count  <= cnt_ff[1];
         rsp_ff.store_hit_count  <= cnt_ff[2];
         rsp_ff.store_miss_count <= cnt_ff[3];
      end
   end

   assign busy      = (state_ff != sacm_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == sacm_pkg::ST_DONE))
      else $error("result without finished access");
   a_no_start_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sacm_pkg::ST_CLEAR) |-> busy)
      else $error("idle during clearing pass");
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.hit) |-> !rsp_ff.dirty_evicted)
      else $error("eviction on hit");
endmodule
`default_nettype wire

// ===== tb/sv/tb_set_assoc_cache_model.sv =====
// Testbench for set_assoc_cache_model: directed and random accesses checked against a tag-store predictor.
`timescale 1ns / 1ps
module tb_set_assoc_cache_model;

   localparam int unsigned N_SETS     = 256;
   localparam int unsigned N_WAYS     = 8;
   localparam int unsigned CYCLE_CAP  = 400000;
   localparam int unsigned SETTLE     = 20;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   sacm_pkg::req_type req_data = '0;
   logic              rsp_valid;
   sacm_pkg::rsp_type rsp_data;
   logic              csr_we = 1'b0;
   logic [2:0]        csr_index = '0;
   logic [3:0]        csr_wdata = '0;

   set_assoc_cache_model u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [31:0] tag_mem [N_SETS*N_WAYS];
   logic        valid_mem [N_SETS*N_WAYS];
   logic        dirty_mem [N_SETS*N_WAYS];
   int          rec_age [N_SETS*N_WAYS];
   int          fifo_age [N_SETS*N_WAYS];
   int          set_fill [N_SETS];
   logic [31:0] cycle_sum;
   logic [31:0] hm_count [4];
   logic [3:0]  cfg_set_bits, cfg_way_count, cfg_offset_bits;
   logic [1:0]  cfg_policy;
   logic        cfg_lru;

   sacm_pkg::req_type pending_items [$];
   sacm_pkg::rsp_type expected_rsps [$];
   int          idle_pct = 0;
   int          errors = 0;
   int unsigned cycle_no = 0;

   initial forever #6 clock = ~clock;

   function automatic logic [31:0] sat32(input logic [31:0] a, input longint b);
      longint s;
      s = longint'(a) + b;
      return (s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
   endfunction

   function automatic int eff_sets();
      return (cfg_set_bits > 8) ? 8 : cfg_set_bits;
   endfunction
   function automatic int eff_ways();
      return (cfg_way_count == 0) ? 1 : ((cfg_way_count > N_WAYS) ? N_WAYS : cfg_way_count);
   endfunction
   function automatic int eff_offset();
      return (cfg_offset_bits < 2) ? 2 : ((cfg_offset_bits > 10) ? 10 : cfg_offset_bits);
   endfunction

   task automatic predict_access(input sacm_pkg::req_type r, output sacm_pkg::rsp_type e);
      logic        st, ht, dev, wb, alc;
      int          sb, wy, ob, pol, set_i, base, n, h, v, slot, j, a, best, vr, vf, k;
      logic [31:0] tg;
      longint      words, cost;
      st = (r.operation == sacm_pkg::OP_STORE);
      sb = eff_sets(); wy = eff_ways(); ob = eff_offset();
      pol = (cfg_policy > sacm_pkg::POL_NOALLOC) ? sacm_pkg::POL_NOALLOC : cfg_policy;
      wb = (pol == sacm_pkg::POL_ALLOC_WB);
      alc = (pol != sacm_pkg::POL_NOALLOC);
      words = 64'd1 << (ob - 2);
      set_i = (r.address >> ob) & ((32'd1 << sb) - 1);
      tg = r.address >> (ob + sb);
      base = set_i * N_WAYS;
      n = (set_fill[set_i] > wy) ? wy : set_fill[set_i];
      ht = 1'b0; dev = 1'b0; h = 0;
      for (j = 0; j < n; j++)
         if (!ht && valid_mem[base+j] && tag_mem[base+j] == tg) begin
            ht = 1'b1; h = j;
         end
      if (ht) begin
         a = rec_age[base+h];
         for (j = 0; j < n; j++)
            if (j != h && valid_mem[base+j] && rec_age[base+j] < a && rec_age[base+j] < 255)
               rec_age[base+j]++;
         rec_age[base+h] = 0;
         if (st && wb) dirty_mem[base+h] = 1'b1;
      end else if (alc || !st) begin
         if (n >= wy) begin
            v = 0; best = 0;
            for (j = 0; j < n; j++) begin
               a = cfg_lru ? rec_age[base+j] : fifo_age[base+j];
               if (j == 0 || a > best) begin
                  best = a; v = j;
               end
            end
            vr = rec_age[base+v]; vf = fifo_age[base+v];
            dev = valid_mem[base+v] && dirty_mem[base+v];
            for (j = 0; j < n; j++)
               if (j != v) begin
                  if (rec_age[base+j] < vr && rec_age[base+j] < 255) rec_age[base+j]++;
                  if (fifo_age[base+j] < vf && fifo_age[base+j] < 255) fifo_age[base+j]++;
               end
            slot = v;
         end else begin
            for (j = 0; j < n; j++) begin
               if (rec_age[base+j] < 255) rec_age[base+j]++;
               if (fifo_age[base+j] < 255) fifo_age[base+j]++;
            end
            slot = n;
            set_fill[set_i] = n + 1;
         end
         tag_mem[base+slot] = tg;
         valid_mem[base+slot] = 1'b1;
         dirty_mem[base+slot] = st && wb;
         rec_age[base+slot] = 0;
         fifo_age[base+slot] = 0;
      end
      if (ht) cost = (st && !wb) ? sacm_pkg::HIT_CYCLES + sacm_pkg::MEM_WORD_CYCLES
                                 : sacm_pkg::HIT_CYCLES;
      else if (!st || wb) cost = sacm_pkg::HIT_CYCLES + sacm_pkg::MEM_WORD_CYCLES * words;
      else if (alc) cost = sacm_pkg::HIT_CYCLES + sacm_pkg::MEM_WORD_CYCLES
                           + sacm_pkg::MEM_WORD_CYCLES * words;
      else cost = sacm_pkg::MEM_WORD_CYCLES;
      if (dev) cost += sacm_pkg::MEM_WORD_CYCLES * words;
      cycle_sum = sat32(cycle_sum, cost);
      k = (st ? 2 : 0) + (ht ? 0 : 1);
      hm_count[k] = sat32(hm_count[k], 1);
      e.hit = ht;
      e.dirty_evicted = dev;
      e.access_cycles = (cost > 65535) ? 16'hFFFF : cost[15:0];
      e.cycles_total = cycle_sum;
      e.load_hit_count = hm_count[0];
      e.load_miss_count = hm_count[1];
      e.store_hit_count = hm_count[2];
      e.store_miss_count = hm_count[3];
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("ERROR cycle %0d: %s got %0h expected %0h", cycle_no, field, got, want);
   endtask

   // driver
   always @(posedge clock) begin
      sacm_pkg::rsp_type exp_rsp;
      if (!reset) begin
         if (start && !busy) begin
            predict_access(req_data, exp_rsp);
            expected_rsps = {expected_rsps, exp_rsp};
            void'(pending_items.pop_front());
         end
         if (!start || !busy) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
               start <= 1'b1;
               req_data <= pending_items[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      sacm_pkg::rsp_type w;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("ERROR cycle %0d: result with no item outstanding", cycle_no);
         end else begin
            w = expected_rsps.pop_front();
            if (rsp_data.hit != w.hit) report_mismatch("hit", rsp_data.hit, w.hit);
            if (rsp_data.dirty_evicted != w.dirty_evicted)
               report_mismatch("dirty_evicted", rsp_data.dirty_evicted, w.dirty_evicted);
            if (rsp_data.access_cycles != w.access_cycles)
               report_mismatch("access_cycles", rsp_data.access_cycles, w.access_cycles);
            if (rsp_data.cycles_total != w.cycles_total)
               report_mismatch("cycles_total", rsp_data.cycles_total, w.cycles_total);
            if (rsp_data.load_hit_count != w.load_hit_count)
               report_mismatch("load_hit_count", rsp_data.load_hit_count, w.load_hit_count);
            if (rsp_data.load_miss_count != w.load_miss_count)
               report_mismatch("load_miss_count", rsp_data.load_miss_count, w.load_miss_count);
            if (rsp_data.store_hit_count != w.store_hit_count)
               report_mismatch("store_hit_count", rsp_data.store_hit_count, w.store_hit_count);
            if (rsp_data.store_miss_count != w.store_miss_count)
               report_mismatch("store_miss_count", rsp_data.store_miss_count,
                               w.store_miss_count);
         end
      end
   end

   always @(posedge clock) begin
      cycle_no++;
      if (cycle_no > CYCLE_CAP) begin
         $display("tb_set_assoc_cache_model NOT OK");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_items.size() > 0 || expected_rsps.size() > 0 || start || busy);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [3:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      case (idx)
         sacm_pkg::CSR_SET_BITS:     cfg_set_bits = val;
         sacm_pkg::CSR_WAY_COUNT:    cfg_way_count = val;
         sacm_pkg::CSR_OFFSET_BITS:  cfg_offset_bits = val;
         sacm_pkg::CSR_WRITE_POLICY: cfg_policy = val[1:0];
         sacm_pkg::CSR_USE_LRU:      cfg_lru = val[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input logic [3:0] sb, input logic [3:0] wy, input logic [3:0] ob,
                             input logic [3:0] pol, input logic [3:0] lru);
      write_csr(sacm_pkg::CSR_SET_BITS, sb);
      write_csr(sacm_pkg::CSR_WAY_COUNT, wy);
      write_csr(sacm_pkg::CSR_OFFSET_BITS, ob);
      write_csr(sacm_pkg::CSR_WRITE_POLICY, pol);
      write_csr(sacm_pkg::CSR_USE_LRU, lru);
   endtask

   task automatic add_item(input logic op, input logic [31:0] addr);
      sacm_pkg::req_type r;
      r.operation = op;
      r.address = addr;
      pending_items = {pending_items, r};
   endtask

   // mostly addresses from a few tags per set so hits and evictions are common
   task automatic add_random(input int count);
      int          sb, ob, wy;
      logic [31:0] addr;
      sb = eff_sets(); ob = eff_offset(); wy = eff_ways();
      repeat (count) begin
         if ($urandom_range(99) < 20) addr = $urandom;
         else addr = ($urandom_range(0, 2 * wy) << (ob + sb))
                   | ($urandom_range(0, 3) << ob)
                   | ($urandom & ((32'd1 << ob) - 1));
         add_item(1'($urandom_range(0, 1)), addr);
      end
   endtask

   initial begin
      int p;
      for (int i = 0; i < N_SETS*N_WAYS; i++) begin
         valid_mem[i] = 1'b0; dirty_mem[i] = 1'b0; rec_age[i] = 0; fifo_age[i] = 0;
         tag_mem[i] = '0;
      end
      for (int i = 0; i < N_SETS; i++) set_fill[i] = 0;
      for (int i = 0; i < 4; i++) hm_count[i] = '0;
      cycle_sum = '0;
      cfg_set_bits = 4'd0; cfg_way_count = 4'd1; cfg_offset_bits = 4'd4;
      cfg_policy = sacm_pkg::POL_ALLOC_WB; cfg_lru = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset config: one way, write-back: hit, dirty hit, dirty and clean evictions
      add_item(sacm_pkg::OP_LOAD, 32'h0);
      add_item(sacm_pkg::OP_LOAD, 32'h4);
      add_item(sacm_pkg::OP_STORE, 32'h8);
      add_item(sacm_pkg::OP_LOAD, 32'h10);
      add_item(sacm_pkg::OP_STORE, 32'h20);
      add_item(sacm_pkg::OP_LOAD, 32'hFFFFFFFF);
      add_item(sacm_pkg::OP_STORE, 32'hFFFFFFF0);
      add_item(sacm_pkg::OP_LOAD, 32'h0);
      wait_idle();
      // two ways, write-through, FIFO: a hit leaves fill order alone
      set_config(4'd0, 4'd2, 4'd2, 4'(sacm_pkg::POL_ALLOC_WT), 4'd0);
      add_item(sacm_pkg::OP_LOAD, 32'h0);
      add_item(sacm_pkg::OP_LOAD, 32'h4);
      add_item(sacm_pkg::OP_LOAD, 32'h0);
      add_item(sacm_pkg::OP_LOAD, 32'h8);
      add_item(sacm_pkg::OP_STORE, 32'h4);
      add_item(sacm_pkg::OP_STORE, 32'h0);
      add_item(sacm_pkg::OP_LOAD, 32'h8);
      wait_idle();
      // no-allocate store misses; unused register indexes are ignored
      set_config(4'd0, 4'd2, 4'd2, 4'(sacm_pkg::POL_NOALLOC), 4'd1);
      write_csr(3'd5, 4'hF);
      write_csr(3'd6, 4'hA);
      write_csr(3'd7, 4'h5);
      add_item(sacm_pkg::OP_STORE, 32'h100);
      add_item(sacm_pkg::OP_STORE, 32'h8);
      add_item(sacm_pkg::OP_LOAD, 32'h100);
      add_item(sacm_pkg::OP_STORE, 32'h100);
      wait_idle();

      for (p = 0; p < 10; p++) begin
         case (p)
            0: set_config(4'd8, 4'd8, 4'd10, 4'(sacm_pkg::POL_ALLOC_WB), 4'd1);
            1: set_config(4'd15, 4'd15, 4'd15, 4'd3, 4'd0);
            2: set_config(4'd0, 4'd0, 4'd0, 4'(sacm_pkg::POL_ALLOC_WT), 4'd1);
            3: set_config(4'd2, 4'd4, 4'd2, 4'(sacm_pkg::POL_NOALLOC), 4'd0);
            4: set_config(4'd3, 4'd2, 4'd5, 4'(sacm_pkg::POL_ALLOC_WB), 4'd0);
            5: set_config(4'd1, 4'd8, 4'd3, 4'(sacm_pkg::POL_ALLOC_WT), 4'd1);
            default: set_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                4'($urandom_range(0, 15)), 4'($urandom_range(0, 3)),
                                4'($urandom_range(0, 1)));
         endcase
         case (p % 4)
            0: idle_pct = 0;
            1: idle_pct = 57;
            2: idle_pct = 11;
            default: idle_pct = $urandom_range(0, 57);
         endcase
         add_random(108);
         wait_idle();
      end

      if (errors == 0) $display("tb_set_assoc_cache_model OK");
      else $display("tb_set_assoc_cache_model NOT OK");
      $finish;
   end
endmodule
